[rtl/core/dwsa_pkg.sv]
// Shared constants, codes and ring-index helper for the deque block.
// No dependencies.
package dwsa_pkg;

	localparam int DEPTH  = 256;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW     = AW + 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int SUM_W  = 40;
	localparam int IDX_W  = 8;
	localparam int CNT_W  = 9;

	typedef enum logic [2:0] {
		FN_PUSH      = 3'd0,
		FN_POP_FRONT = 3'd1,
		FN_POP_BACK  = 3'd2,
		FN_SEARCH    = 3'd3,
		FN_QUERY     = 3'd4
	} func_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// (base + offset) mod DEPTH, offset below 2*DEPTH - base
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
		input logic [PW-1:0] offs);
		logic [PW:0] s;
		s = {2'b00, base} + {1'b0, offs};
		if (s >= (PW+1)'(DEPTH)) begin
			s = s - (PW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

endpackage

[rtl/core/dwsa_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module dwsa_ram #(
	parameter int DW    = 32,
	parameter int AW    = 8,
	parameter int DEPTH = 256
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/dwsa_div.sv]
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle,
// truncation toward zero. Depends on dwsa_pkg.
module dwsa_div import dwsa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CW-1:0]           divisor,
	output logic                    done,
	output logic [DATA_W-1:0]       quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  q_q;
	logic [CW-1:0]     rem_q;
	logic [CW-1:0]     dvs_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;

	logic [CW:0]       rem_sh;
	logic              ge;
	logic [SUM_W-1:0]  res;

	assign rem_sh = {rem_q, q_q[SUM_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign res    = neg_q ? (~q_q + SUM_W'(1)) : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q    <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			neg_q  <= 1'b0;
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q  <= dividend[SUM_W-1];
				q_q    <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
				step_q <= STEP_W'(SUM_W);
				run_q  <= 1'b1;
			end else if (run_q) begin
				rem_q  <= ge ? CW'(rem_sh - {1'b0, dvs_q}) : CW'(rem_sh);
				q_q    <= {q_q[SUM_W-2:0], ge};
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = res[DATA_W-1:0];

endmodule

[rtl/core/deque_with_search_and_average_top.sv]
// Deque of signed 32-bit values in a ring RAM, with search and running mean.
// Depends on dwsa_pkg, dwsa_ram, dwsa_div.
//
//   channel   handshake         payload
//   command   start / busy      func, value
//   result    done (strobe)     status, found_index, entry_count,
//                               mean_value, mean_valid
//
// One command at a time. Push, query and failed ops go straight to the mean
// division; a pop first reads its entry, and a search reads entries from the
// front until a match or the last entry. The 40-step serial divider for the
// mean and the single RAM read port (one entry per cycle) set how long each
// command takes.
// Reset empties the queue at once; RAM contents are not cleared.
// busy drops in the cycle the result shows; the receiver cannot stall.
module deque_with_search_and_average_top import dwsa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               func,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic [1:0]               status,
	output logic [IDX_W-1:0]         found_index,
	output logic [CNT_W-1:0]         entry_count,
	output logic signed [DATA_W-1:0] mean_value,
	output logic                     mean_valid
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_READ     = 5'b00010,
		S_SEARCH   = 5'b00100,
		S_DIV_GO   = 5'b01000,
		S_DIV_WAIT = 5'b10000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     occ_q;
	logic [SUM_W-1:0]  sum_q;
	logic [2:0]        fn_q;
	logic [DATA_W-1:0] val_q;
	logic [AW-1:0]     idx_q;
	logic [1:0]        status_q;
	logic [AW-1:0]     found_q;
	logic [DATA_W-1:0] mean_q;
	logic              done_q;

	logic              accept;
	logic              full;
	logic              empty;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic              div_done;
	logic [DATA_W-1:0] div_quot;
	logic [PW-1:0]     idx_next;

	assign accept    = start && !busy;
	assign full      = occ_q >= CW'(DEPTH);
	assign empty     = occ_q == '0;
	assign ram_we    = accept && (func == FN_PUSH) && !full;
	assign ram_waddr = ring_add(head_q, PW'(occ_q));
	assign idx_next  = PW'(idx_q) + PW'(1);

	always_comb begin
		case (state_q)
			S_SEARCH: ram_raddr = ring_add(head_q, idx_next);
			default: begin
				if (func == FN_POP_BACK) begin
					ram_raddr = ring_add(head_q, PW'(occ_q) - PW'(1));
				end else begin
					ram_raddr = head_q;
				end
			end
		endcase
	end

	dwsa_ram #(
		.DW    (DATA_W),
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dwsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIV_GO),
		.dividend (sum_q),
		.divisor  (occ_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			occ_q    <= '0;
			sum_q    <= '0;
			fn_q     <= '0;
			val_q    <= '0;
			idx_q    <= '0;
			status_q <= ST_OK;
			found_q  <= '0;
			mean_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fn_q     <= func;
						val_q    <= value;
						idx_q    <= '0;
						found_q  <= '0;
						status_q <= ST_OK;
						state_q  <= S_DIV_GO;
						case (func)
							FN_PUSH: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									occ_q <= occ_q + CW'(1);
									sum_q <= sum_q + {{(SUM_W-DATA_W){value[DATA_W-1]}}, value};
								end
							end
							FN_POP_FRONT, FN_POP_BACK: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_READ;
								end
							end
							FN_SEARCH: begin
								if (empty) begin
									status_q <= ST_NOT_FOUND;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					// read beat for the popped entry lands here
					sum_q <= sum_q - {{(SUM_W-DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
					occ_q <= occ_q - CW'(1);
					if (fn_q == FN_POP_FRONT) begin
						head_q <= ring_add(head_q, PW'(1));
					end
					state_q <= S_DIV_GO;
				end
				S_SEARCH: begin
					// ram_rdata holds entry idx_q; next address already issued
					if (ram_rdata == val_q) begin
						found_q <= idx_q;
						state_q <= S_DIV_GO;
					end else if (CW'(idx_next) == occ_q) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_DIV_GO;
					end else begin
						idx_q <= idx_next[AW-1:0];
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						mean_q  <= empty ? '0 : div_quot;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign found_index = IDX_W'(found_q);
	assign entry_count = CNT_W'(occ_q);
	assign mean_value  = mean_q;
	assign mean_valid  = !empty;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted command did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe outside idle");

	a_mean_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && empty) |-> (mean_q == '0))
		else $error("mean nonzero on empty queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (occ_q == $past(occ_q) + CW'(1)))
		else $error("push did not bump occupancy");

endmodule
